[rtl/tce_pkg.sv]
// shared types and codes of the toy cpu execute unit
// no dependencies; used by tce_cfg, the execute unit and its testbench
package tce_pkg;

  typedef enum logic [3:0] {
    OP_ILLOP  = 4'd0,
    OP_NOP    = 4'd1,
    OP_LOAD   = 4'd2,
    OP_STORE  = 4'd3,
    OP_ADD    = 4'd4,
    OP_SUB    = 4'd5,
    OP_BRANCH = 4'd6,
    OP_CALL   = 4'd7,
    OP_RET    = 4'd8,
    OP_PUSH   = 4'd9,
    OP_POP    = 4'd10,
    OP_HALT   = 4'd11
  } op_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_HALTED   = 4'd1,
    ST_ILLEGAL  = 4'd2,
    ST_UNKNOWN  = 4'd3,
    ST_BAD_COND = 4'd4,
    ST_IMM      = 4'd5,
    ST_DATA_SEG = 4'd6,
    ST_TEXT_SEG = 4'd7,
    ST_STACK    = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    CC_ZERO = 2'd0,
    CC_POS  = 2'd1,
    CC_NEG  = 2'd2
  } cc_e;

  typedef enum logic [3:0] {
    COND_NC = 4'd0,
    COND_EQ = 4'd1,
    COND_NE = 4'd2,
    COND_GT = 4'd3,
    COND_GE = 4'd4,
    COND_LT = 4'd5,
    COND_LE = 4'd6
  } cond_e;

  localparam logic [3:0] CondMax = 4'd6;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MEM  = 2'd1,
    S_WB   = 2'd2
  } state_e;

  localparam logic [0:0] RegDataSize = 1'b0;
  localparam logic [0:0] RegTextSize = 1'b1;
  localparam logic [10:0] DataSizeRst = 11'd1024;
  localparam logic [12:0] TextSizeRst = 13'd4096;

  typedef struct packed {
    logic [3:0]         opcode;
    logic               immediate_mode;
    logic               indexed_mode;
    logic [3:0]         reg_or_cond;
    logic signed [19:0] imm_value;
    logic [19:0]        abs_address;
    logic [3:0]         index_reg;
    logic signed [15:0] index_offset;
  } tce_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] next_pc;
    logic [1:0]  cond_code;
  } tce_out_t;

  typedef struct packed {
    logic [10:0] data_size;
    logic [12:0] text_size;
  } tce_cfg_t;

endpackage

[rtl/tce_cfg.sv]
// apb configuration registers: data_size and text_size
// depends on tce_pkg
module tce_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tce_pkg::tce_cfg_t cfg_o
);

  logic [10:0] data_size_q, data_size_d;
  logic [12:0] text_size_q, text_size_d;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    data_size_d = data_size_q;
    text_size_d = text_size_q;
    if (wr) begin
      if (paddr[2] == tce_pkg::RegDataSize) begin
        data_size_d = pwdata[10:0];
      end else begin
        text_size_d = pwdata[12:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q <= tce_pkg::DataSizeRst;
      text_size_q <= tce_pkg::TextSizeRst;
    end else begin
      data_size_q <= data_size_d;
      text_size_q <= text_size_d;
    end
  end

  always_comb begin
    if (paddr[2] == tce_pkg::RegDataSize) begin
      prdata = {21'd0, data_size_q};
    end else begin
      prdata = {19'd0, text_size_q};
    end
  end

  assign cfg_o.data_size = data_size_q;
  assign cfg_o.text_size = text_size_q;

endmodule

[rtl/tce_regfile.sv]
// register file: one write port, two registered read ports, zero after reset
// per-entry valid bits; a read in the cycle of a write to the same entry is forwarded
module tce_regfile #(
  parameter int NUM_REGS   = 16,
  parameter int WORD_WIDTH = 32,
  parameter int RW         = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  re_i,
  input  logic [RW-1:0]         ra_a_i,
  input  logic [RW-1:0]         ra_b_i,
  input  logic                  we_i,
  input  logic [RW-1:0]         wa_i,
  input  logic [WORD_WIDTH-1:0] wd_i,
  output logic [WORD_WIDTH-1:0] rd_a_o,
  output logic [WORD_WIDTH-1:0] rd_b_o
);

  logic [WORD_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   vld_q;
  logic [WORD_WIDTH-1:0] ram_a_q, ram_b_q, fwd_q;
  logic                  vld_a_q, vld_b_q, fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      ram_a_q <= mem[ra_a_i];
      ram_b_q <= mem[ra_b_i];
      fwd_q   <= wd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wa_i] <= 1'b1;
      end
      if (re_i) begin
        vld_a_q <= vld_q[ra_a_i];
        vld_b_q <= vld_q[ra_b_i];
        fwd_a_q <= we_i && (wa_i == ra_a_i);
        fwd_b_q <= we_i && (wa_i == ra_b_i);
      end
    end
  end

  assign rd_a_o = fwd_a_q ? fwd_q : (vld_a_q ? ram_a_q : '0);
  assign rd_b_o = fwd_b_q ? fwd_q : (vld_b_q ? ram_b_q : '0);

endmodule

[rtl/tce_dmem.sv]
// data memory: one read and one write port, registered read data
// clears every word after reset, one word a cycle, while busy_o is high
module tce_dmem #(
  parameter int DATA_DEPTH = 1024,
  parameter int WORD_WIDTH = 32,
  parameter int DW         = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  re_i,
  input  logic [DW-1:0]         ra_i,
  input  logic                  we_i,
  input  logic [DW-1:0]         wa_i,
  input  logic [WORD_WIDTH-1:0] wd_i,
  output logic [WORD_WIDTH-1:0] rd_o,
  output logic                  busy_o
);

  logic [WORD_WIDTH-1:0] mem [DATA_DEPTH];
  logic [WORD_WIDTH-1:0] rd_q;
  logic                  clr_q, clr_d;
  logic [DW-1:0]         clr_idx_q, clr_idx_d;
  logic                  mem_we;
  logic [DW-1:0]         mem_wa;
  logic [WORD_WIDTH-1:0] mem_wd;

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      if (clr_idx_q == DW'(DATA_DEPTH - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  assign mem_we = clr_q | we_i;
  assign mem_wa = clr_q ? clr_idx_q : wa_i;
  assign mem_wd = clr_q ? '0 : wd_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o   = rd_q;
  assign busy_o = clr_q;

endmodule

[rtl/toy_cpu_execute_unit.sv]
// Execute unit of a small register machine: one decoded instruction per input
// transaction, one result (status, next pc, condition code) per instruction.
// Each instruction passes the states S_MEM and S_WB: the register file is read at
// acceptance, the data memory is read in S_MEM and the writeback is done in S_WB,
// where the next instruction can already be accepted, so a new instruction is taken
// only as the last one is written back.
// A result waiting in the output register stalls the writeback. After reset the
// data memory is cleared, during which no instruction is accepted; configuration
// writes are taken at any time.
// depends on tce_pkg, tce_cfg, tce_regfile, tce_dmem
module toy_cpu_execute_unit #(
  parameter int NUM_REGS   = 16,
  parameter int DATA_DEPTH = 1024,
  parameter int TEXT_DEPTH = 4096,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tce_pkg::tce_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tce_pkg::tce_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int DW = $clog2(DATA_DEPTH);
  localparam int PW = $clog2(TEXT_DEPTH);
  localparam int AW = (DW > PW) ? DW : PW;
  localparam int WW = WORD_WIDTH;
  localparam int SW = (WW + 1 > 21) ? WW + 1 : 21;
  localparam int CW = (WW > 17) ? WW : 17;
  localparam logic [16:0] DataLim = 17'(DATA_DEPTH);
  localparam logic [16:0] TextLim = 17'(TEXT_DEPTH);

  function automatic logic [RW-1:0] reg_sel(input logic [3:0] v);
    logic [4:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 5'(NUM_REGS)) r = r - 5'(NUM_REGS);
    end
    return r[RW-1:0];
  endfunction

  tce_pkg::tce_cfg_t cfg;
  tce_pkg::state_e   state_q, state_d;
  tce_pkg::tce_in_t  in_q;
  tce_pkg::tce_out_t out_q, out_d;
  tce_pkg::cc_e      cc_q, cc_d;
  logic              out_valid_q, out_valid_d;
  logic [PW-1:0]     pc_q, pc_d;
  logic [DW-1:0]     sp_q, sp_d;
  logic [AW-1:0]     addr_q;
  logic              addr_ok_q;

  logic              busy, accept, can_finish, finish;
  logic [16:0]       dsz, tsz;
  logic [WW-1:0]     rd_a, rd_b, mem_rd;
  logic              rf_we;
  logic [WW-1:0]     rf_wd;
  logic              dm_re, dm_we;
  logic [DW-1:0]     dm_ra, dm_wa;
  logic [WW-1:0]     dm_wd;
  logic [SW-1:0]     sum;
  logic              addr_ok;
  tce_pkg::op_e      op;

  tce_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  tce_regfile #(.NUM_REGS(NUM_REGS), .WORD_WIDTH(WW), .RW(RW)) u_rf (
    .clk_i, .rst_ni,
    .re_i   (accept),
    .ra_a_i (reg_sel(in_data_i.reg_or_cond)),
    .ra_b_i (reg_sel(in_data_i.index_reg)),
    .we_i   (rf_we),
    .wa_i   (reg_sel(in_q.reg_or_cond)),
    .wd_i   (rf_wd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  tce_dmem #(.DATA_DEPTH(DATA_DEPTH), .WORD_WIDTH(WW), .DW(DW)) u_dm (
    .clk_i, .rst_ni,
    .re_i   (dm_re),
    .ra_i   (dm_ra),
    .we_i   (dm_we),
    .wa_i   (dm_wa),
    .wd_i   (dm_wd),
    .rd_o   (mem_rd),
    .busy_o (busy)
  );

  assign dsz = ({6'd0, cfg.data_size} < DataLim) ? {6'd0, cfg.data_size} : DataLim;
  assign tsz = ({4'd0, cfg.text_size} < TextLim) ? {4'd0, cfg.text_size} : TextLim;
  assign op    = tce_pkg::op_e'(in_q.opcode);

  assign can_finish = !out_valid_q || out_ready_i;
  assign finish     = (state_q == tce_pkg::S_WB) && can_finish;
  assign in_ready_o = !busy && ((state_q == tce_pkg::S_IDLE) || finish);
  assign accept     = in_valid_i && in_ready_o;

  // operand address, resolved in the memory-read cycle
  always_comb begin
    logic [16:0] bound;
    if (in_q.indexed_mode) begin
      sum = SW'($signed(rd_b)) + SW'(in_q.index_offset);
    end else begin
      sum = SW'(in_q.abs_address);
    end
    bound   = (op == tce_pkg::OP_BRANCH || op == tce_pkg::OP_CALL) ? tsz : dsz;
    addr_ok = !sum[SW-1] && (sum < SW'(bound));
    dm_re   = (state_q == tce_pkg::S_MEM);
    if (op == tce_pkg::OP_RET || op == tce_pkg::OP_POP) begin
      dm_ra = sp_q + 1'b1;
    end else begin
      dm_ra = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (state_q == tce_pkg::S_MEM) begin
      addr_q    <= sum[AW-1:0];
      addr_ok_q <= addr_ok;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  // writeback: status, state updates, register file and memory writes
  always_comb begin
    tce_pkg::status_e st;
    logic [PW-1:0]    npc, pc_new;
    logic [WW-1:0]    imm_w, v, res;
    logic             push_ok, pop_ok, taken;
    logic [16:0]      sp_inc, pc_ext;
    st      = tce_pkg::ST_OK;
    npc     = (pc_q == PW'(TEXT_DEPTH - 1)) ? '0 : pc_q + 1'b1;
    pc_new  = npc;
    imm_w   = WW'(in_q.imm_value);
    v       = in_q.immediate_mode ? imm_w : mem_rd;
    sp_inc  = 17'(sp_q) + 17'd1;
    push_ok = (sp_q != '0) && (17'(sp_q) < dsz);
    pop_ok  = sp_inc < dsz;
    res     = v;
    sp_d    = sp_q;
    cc_d    = cc_q;
    rf_we   = 1'b0;
    dm_we   = 1'b0;
    dm_wa   = sp_q;
    dm_wd   = v;
    case (tce_pkg::cond_e'(in_q.reg_or_cond))
      tce_pkg::COND_NC: taken = 1'b1;
      tce_pkg::COND_EQ: taken = (cc_q == tce_pkg::CC_ZERO);
      tce_pkg::COND_NE: taken = (cc_q != tce_pkg::CC_ZERO);
      tce_pkg::COND_GT: taken = (cc_q == tce_pkg::CC_POS);
      tce_pkg::COND_GE: taken = (cc_q != tce_pkg::CC_NEG);
      tce_pkg::COND_LT: taken = (cc_q == tce_pkg::CC_NEG);
      default:          taken = (cc_q != tce_pkg::CC_POS);
    endcase
    case (op)
      tce_pkg::OP_ILLOP: st = tce_pkg::ST_ILLEGAL;
      tce_pkg::OP_NOP:   st = tce_pkg::ST_OK;
      tce_pkg::OP_LOAD, tce_pkg::OP_ADD, tce_pkg::OP_SUB: begin
        if (!in_q.immediate_mode && !addr_ok_q) begin
          st = tce_pkg::ST_DATA_SEG;
        end else begin
          if (op == tce_pkg::OP_ADD) res = rd_a + v;
          else if (op == tce_pkg::OP_SUB) res = rd_a - v;
          rf_we = 1'b1;
          if (res == '0) cc_d = tce_pkg::CC_ZERO;
          else if (res[WW-1]) cc_d = tce_pkg::CC_NEG;
          else cc_d = tce_pkg::CC_POS;
        end
      end
      tce_pkg::OP_STORE: begin
        if (in_q.immediate_mode) st = tce_pkg::ST_IMM;
        else if (!addr_ok_q) st = tce_pkg::ST_DATA_SEG;
        else begin
          dm_we = 1'b1;
          dm_wa = addr_q[DW-1:0];
          dm_wd = rd_a;
        end
      end
      tce_pkg::OP_BRANCH, tce_pkg::OP_CALL: begin
        if (in_q.immediate_mode) st = tce_pkg::ST_IMM;
        else if (in_q.reg_or_cond > tce_pkg::CondMax) st = tce_pkg::ST_BAD_COND;
        else if (taken) begin
          if (op == tce_pkg::OP_CALL && !push_ok) st = tce_pkg::ST_STACK;
          else if (!addr_ok_q) st = tce_pkg::ST_TEXT_SEG;
          else begin
            if (op == tce_pkg::OP_CALL) begin
              dm_we = 1'b1;
              dm_wd = WW'(npc);
              sp_d  = sp_q - 1'b1;
            end
            pc_new = addr_q[PW-1:0];
          end
        end
      end
      tce_pkg::OP_RET: begin
        if (!pop_ok) st = tce_pkg::ST_STACK;
        else if (CW'(mem_rd) >= CW'(tsz)) st = tce_pkg::ST_TEXT_SEG;
        else begin
          sp_d   = sp_inc[DW-1:0];
          pc_new = mem_rd[PW-1:0];
        end
      end
      tce_pkg::OP_PUSH: begin
        if (!in_q.immediate_mode && !addr_ok_q) st = tce_pkg::ST_DATA_SEG;
        else if (!push_ok) st = tce_pkg::ST_STACK;
        else begin
          dm_we = 1'b1;
          sp_d  = sp_q - 1'b1;
        end
      end
      tce_pkg::OP_POP: begin
        if (in_q.immediate_mode) st = tce_pkg::ST_IMM;
        else if (!addr_ok_q) st = tce_pkg::ST_DATA_SEG;
        else if (!pop_ok) st = tce_pkg::ST_STACK;
        else begin
          dm_we = 1'b1;
          dm_wa = addr_q[DW-1:0];
          dm_wd = mem_rd;
          sp_d  = sp_inc[DW-1:0];
        end
      end
      tce_pkg::OP_HALT: st = tce_pkg::ST_HALTED;
      default:          st = tce_pkg::ST_UNKNOWN;
    endcase
    pc_d = (st == tce_pkg::ST_OK || st == tce_pkg::ST_HALTED) ? pc_new : pc_q;
    // the writes only land when the result can be handed over
    rf_we  = rf_we && finish;
    dm_we  = dm_we && finish;
    rf_wd  = res;
    pc_ext = 17'(pc_d);
    out_d.status    = st;
    out_d.next_pc   = pc_ext[11:0];
    out_d.cond_code = cc_d;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      tce_pkg::S_IDLE: if (accept) state_d = tce_pkg::S_MEM;
      tce_pkg::S_MEM:  state_d = tce_pkg::S_WB;
      tce_pkg::S_WB: begin
        if (finish) begin
          out_valid_d = 1'b1;
          state_d     = accept ? tce_pkg::S_MEM : tce_pkg::S_IDLE;
        end
      end
      default: state_d = tce_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tce_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      sp_q        <= DW'(DATA_DEPTH - 1);
      cc_q        <= tce_pkg::CC_ZERO;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        pc_q <= pc_d;
        sp_q <= sp_d;
        cc_q <= cc_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[verif/tb_toy_cpu_execute_unit.sv]
// testbench of the toy cpu execute unit: directed and random instructions,
// a shadow machine in a scoreboard class predicts every result
// depends on tce_pkg and toy_cpu_execute_unit
module tb_toy_cpu_execute_unit;
  import tce_pkg::*;

  localparam int NumRegs   = 16;
  localparam int DataDepth = 1024;
  localparam int TextDepth = 4096;
  localparam int WdLimit   = 6000;
  localparam int HoldLen   = 300;

  class exec_scoreboard;
    bit [31:0] regs[NumRegs];
    bit [31:0] dmem[DataDepth];
    int        pc;
    int        sp;
    cc_e       cc;
    int        data_size;
    int        text_size;
    tce_out_t  pending[$];
    int        errors;
    int        status_hits[16];

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = 0;
      sp = DataDepth - 1;
      cc = CC_ZERO;
      data_size = 1024;
      text_size = 4096;
      errors = 0;
    endfunction

    function cc_e cc_from(bit [31:0] w);
      if (w == 0) return CC_ZERO;
      return w[31] ? CC_NEG : CC_POS;
    endfunction

    function bit cond_true(logic [3:0] c);
      case (c)
        COND_NC: return 1'b1;
        COND_EQ: return cc == CC_ZERO;
        COND_NE: return cc != CC_ZERO;
        COND_GT: return cc == CC_POS;
        COND_GE: return cc != CC_NEG;
        COND_LT: return cc == CC_NEG;
        default: return cc != CC_POS;
      endcase
    endfunction

    // operand address, true when inside [0, bound)
    function bit eff_addr(tce_in_t it, int bound, output int addr);
      longint a;
      if (it.indexed_mode)
        a = longint'($signed(regs[it.index_reg % NumRegs])) + longint'($signed(it.index_offset));
      else
        a = longint'(it.abs_address);
      addr = int'(a);
      return a >= 0 && a < bound;
    endfunction

    function void note_instr(tce_in_t it);
      status_e   st;
      int        npc, addr, dsz, tsz, r;
      bit [31:0] v, immw;
      tce_out_t  e;
      st = ST_OK;
      npc = (pc + 1) % TextDepth;
      dsz = data_size < DataDepth ? data_size : DataDepth;
      tsz = text_size < TextDepth ? text_size : TextDepth;
      r = it.reg_or_cond % NumRegs;
      immw = {{12{it.imm_value[19]}}, it.imm_value};
      addr = 0;
      case (it.opcode)
        OP_ILLOP: st = ST_ILLEGAL;
        OP_NOP: ;
        OP_LOAD, OP_ADD, OP_SUB: begin
          if (it.immediate_mode) v = immw;
          else if (eff_addr(it, dsz, addr)) v = dmem[addr];
          else st = ST_DATA_SEG;
          if (st == ST_OK) begin
            if (it.opcode == OP_ADD) v = regs[r] + v;
            else if (it.opcode == OP_SUB) v = regs[r] - v;
            regs[r] = v;
            cc = cc_from(v);
          end
        end
        OP_STORE: begin
          if (it.immediate_mode) st = ST_IMM;
          else if (!eff_addr(it, dsz, addr)) st = ST_DATA_SEG;
          else dmem[addr] = regs[r];
        end
        OP_BRANCH, OP_CALL: begin
          if (it.immediate_mode) st = ST_IMM;
          else if (it.reg_or_cond > CondMax) st = ST_BAD_COND;
          else if (cond_true(it.reg_or_cond)) begin
            if (it.opcode == OP_CALL && (sp == 0 || sp >= dsz)) st = ST_STACK;
            else if (!eff_addr(it, tsz, addr)) st = ST_TEXT_SEG;
            else begin
              if (it.opcode == OP_CALL) begin
                dmem[sp] = npc;
                sp--;
              end
              npc = addr;
            end
          end
        end
        OP_RET: begin
          if (sp + 1 >= dsz) st = ST_STACK;
          else if (dmem[sp + 1] >= tsz) st = ST_TEXT_SEG;
          else begin
            sp++;
            npc = dmem[sp];
          end
        end
        OP_PUSH: begin
          if (it.immediate_mode) v = immw;
          else if (eff_addr(it, dsz, addr)) v = dmem[addr];
          else st = ST_DATA_SEG;
          if (st == ST_OK) begin
            if (sp == 0 || sp >= dsz) st = ST_STACK;
            else begin
              dmem[sp] = v;
              sp--;
            end
          end
        end
        OP_POP: begin
          if (it.immediate_mode) st = ST_IMM;
          else if (!eff_addr(it, dsz, addr)) st = ST_DATA_SEG;
          else if (sp + 1 >= dsz) st = ST_STACK;
          else begin
            sp++;
            dmem[addr] = dmem[sp];
          end
        end
        OP_HALT: st = ST_HALTED;
        default: st = ST_UNKNOWN;
      endcase
      if (st == ST_OK || st == ST_HALTED) pc = npc;
      status_hits[st]++;
      e.status = st;
      e.next_pc = pc[11:0];
      e.cond_code = cc;
      pending.push_back(e);
    endfunction

    function void check_result(tce_out_t got);
      tce_out_t e;
      if (pending.size() == 0) begin
        $error("result with no instruction outstanding: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc: expected %0d, actual %0d", e.next_pc, got.next_pc);
        errors++;
      end
      if (got.cond_code !== e.cond_code) begin
        $error("cond_code: expected %0d, actual %0d", e.cond_code, got.cond_code);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tce_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tce_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  exec_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  toy_cpu_execute_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt = HoldLen;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_instr(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WdLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_instr(tce_in_t it);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) sb.data_size = data[10:0];
    else sb.text_size = data[12:0];
  endtask

  task automatic set_sizes(int dsz, int tsz);
    apb_write(3'(4 * RegDataSize), dsz);
    apb_write(3'(4 * RegTextSize), tsz);
  endtask

  function automatic tce_in_t mk(logic [3:0] op, bit imm, bit idx, logic [3:0] rc,
                                 int immv, int abs_a, logic [3:0] ir, int off);
    tce_in_t it;
    it.opcode = op;
    it.immediate_mode = imm;
    it.indexed_mode = idx;
    it.reg_or_cond = rc;
    it.imm_value = immv[19:0];
    it.abs_address = abs_a[19:0];
    it.index_reg = ir;
    it.index_offset = off[15:0];
    return it;
  endfunction

  function automatic tce_in_t rand_instr();
    tce_in_t it;
    int      pick, bound;
    pick = $urandom_range(0, 99);
    if (pick < 3) it.opcode = OP_ILLOP;
    else if (pick < 6) it.opcode = OP_NOP;
    else if (pick < 8) it.opcode = OP_HALT;
    else if (pick < 10) it.opcode = 4'($urandom_range(12, 15));
    else it.opcode = 4'($urandom_range(OP_LOAD, OP_POP));
    bound = (it.opcode == OP_BRANCH || it.opcode == OP_CALL) ? sb.text_size : sb.data_size;
    if (bound > 1024 && it.opcode != OP_BRANCH && it.opcode != OP_CALL) bound = 1024;
    if (bound > 4096) bound = 4096;
    it.immediate_mode = ($urandom_range(0, 99) < 20);
    it.indexed_mode = ($urandom_range(0, 99) < 35);
    if ((it.opcode == OP_BRANCH || it.opcode == OP_CALL) && $urandom_range(0, 9) != 0)
      it.reg_or_cond = 4'($urandom_range(0, CondMax));
    else
      it.reg_or_cond = 4'($urandom);
    if ($urandom_range(0, 1)) it.imm_value = 20'($urandom_range(0, 200) - 100);
    else it.imm_value = 20'($urandom);
    if ($urandom_range(0, 99) < 85) it.abs_address = 20'($urandom_range(0, bound - 1));
    else it.abs_address = 20'($urandom);
    it.index_reg = 4'($urandom);
    if ($urandom_range(0, 99) < 70) it.index_offset = 16'($urandom_range(0, 64) - 32);
    else it.index_offset = 16'($urandom);
    return it;
  endfunction

  initial begin
    int dsz_set[6] = '{1024, 1, 16, 200, 1024, 1024};
    int tsz_set[6] = '{4096, 1, 64, 4096, 1, 4096};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every opcode, field extremes, fault ordering
    send_instr(mk(OP_ILLOP, 0, 0, 0, 0, 0, 0, 0));
    send_instr(mk(OP_NOP, 0, 0, 0, 0, 0, 0, 0));
    send_instr(mk(4'd12, 0, 0, 0, 0, 0, 0, 0));
    send_instr(mk(4'd15, 1, 1, 15, -1, 'hFFFFF, 15, -1));
    send_instr(mk(OP_LOAD, 1, 1, 1, 'h7FFFF, 0, 0, 0));
    send_instr(mk(OP_LOAD, 1, 0, 2, -524288, 0, 0, 0));
    send_instr(mk(OP_ADD, 1, 0, 1, 1, 0, 0, 0));
    send_instr(mk(OP_SUB, 1, 0, 3, 0, 0, 0, 0));
    send_instr(mk(OP_STORE, 0, 0, 1, 0, 5, 0, 0));
    send_instr(mk(OP_LOAD, 0, 0, 4, 0, 5, 0, 0));
    send_instr(mk(OP_STORE, 1, 0, 1, 0, 5, 0, 0));
    send_instr(mk(OP_STORE, 0, 0, 1, 0, 'hFFFFF, 0, 0));
    send_instr(mk(OP_LOAD, 0, 1, 5, 0, 0, 2, 32767));
    send_instr(mk(OP_LOAD, 0, 1, 5, 0, 0, 0, -32768));
    send_instr(mk(OP_LOAD, 0, 1, 5, 0, 0, 0, 5));
    send_instr(mk(OP_BRANCH, 0, 0, 7, 0, 10, 0, 0));
    send_instr(mk(OP_BRANCH, 1, 0, 15, 0, 10, 0, 0));
    send_instr(mk(OP_BRANCH, 0, 0, COND_NC, 0, 4095, 0, 0));
    send_instr(mk(OP_CALL, 0, 0, COND_NC, 0, 200, 0, 0));
    send_instr(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));
    send_instr(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));
    send_instr(mk(OP_PUSH, 1, 0, 0, 4096, 0, 0, 0));
    send_instr(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));
    send_instr(mk(OP_POP, 1, 0, 0, 0, 3, 0, 0));
    send_instr(mk(OP_BRANCH, 0, 0, COND_EQ, 0, 'hFFFFF, 0, 0));
    send_instr(mk(OP_CALL, 0, 0, COND_NC, 0, 5000, 0, 0));
    send_instr(mk(OP_HALT, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random segments, each with sizes from a table and one of four idling mixes
    for (int seg = 0; seg < 6; seg++) begin
      set_sizes(dsz_set[seg], tsz_set[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (seg == 0) hold_req = 1'b1;
      for (int n = 0; n < 200; n++) send_instr(rand_instr());
      drain();
    end

    $display("ran %0d ok, %0d halted, %0d illegal, %0d unknown, %0d bad cond results",
             sb.status_hits[ST_OK], sb.status_hits[ST_HALTED], sb.status_hits[ST_ILLEGAL],
             sb.status_hits[ST_UNKNOWN], sb.status_hits[ST_BAD_COND]);
    $display("faults: %0d immediate, %0d data seg, %0d text seg, %0d stack; six size settings",
             sb.status_hits[ST_IMM], sb.status_hits[ST_DATA_SEG],
             sb.status_hits[ST_TEXT_SEG], sb.status_hits[ST_STACK]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/tce_pkg.sv
rtl/tce_cfg.sv
rtl/tce_regfile.sv
rtl/tce_dmem.sv
rtl/toy_cpu_execute_unit.sv
verif/tb_toy_cpu_execute_unit.sv
